FILE: rtl/core/fct_pkg.sv
// Shared types, constants and address helpers for the floor cast texel shader.
// No dependencies; every other file in rtl/core imports this package.
package fct_pkg;

  localparam int MAP_SIDE    = 64;
  localparam int LAYERS      = 4;
  localparam int TEXTURES    = 8;
  localparam int TILE_SIDE   = 64;

  localparam int CELL_COUNT  = LAYERS * MAP_SIDE * MAP_SIDE;
  localparam int TEXEL_COUNT = TEXTURES * TILE_SIDE * TILE_SIDE;
  localparam int CELL_AW     = $clog2(CELL_COUNT);
  localparam int TEXEL_AW    = $clog2(TEXEL_COUNT);
  localparam int MAP_W       = $clog2(MAP_SIDE);
  localparam int TILE_SH     = $clog2(TILE_SIDE);
  localparam int TEX_AW      = (TEXTURES > 1) ? $clog2(TEXTURES) : 1;

  localparam int WORLD_W     = 20;
  localparam int DIV_STAGES  = 32;
  localparam int MID_DEPTH   = 4;
  localparam int MID_AW      = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_AW      = $clog2(OUT_DEPTH);

  localparam logic [23:0] HALF_MASK = 24'h7F7F7F;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_ROW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_DIST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_LEVEL  = 3'd5;

  typedef enum logic [1:0] {
    OP_LOAD_CELL  = 2'd0,
    OP_LOAD_TEXEL = 2'd1,
    OP_CAST       = 2'd2
  } op_t;

  typedef struct packed {
    logic [11:0]        player_height;
    logic signed [10:0] horizon_row;
    logic [10:0]        projection_distance;
    logic [11:0]        viewer_x;
    logic [11:0]        viewer_y;
    logic [1:0]         viewer_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    player_height:       12'd32,
    horizon_row:         11'sd0,
    projection_distance: 11'd277,
    viewer_x:            12'd0,
    viewer_y:            12'd0,
    viewer_level:        2'd0
  };

  // item as it travels through the front pipeline
  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         lv;
    logic [5:0]         cx;
    logic [5:0]         cy;
    logic [2:0]         tex;
    logic               wall;
    logic               light;
    logic [23:0]        color;
    logic [9:0]         row;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    logic [14:0]        fe;
    logic               kill;
  } fitem_t;

  typedef struct packed {
    fitem_t      item;
    logic [10:0] rem;
    logic [31:0] sh;
    logic [10:0] den;
    logic        ovf;
    logic        neg;
  } div_t;

  // word handed from front to back
  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         lv;
    logic [MAP_W-1:0]   cx;
    logic [MAP_W-1:0]   cy;
    logic               ok;
    logic [2:0]         tex;
    logic               wall;
    logic               light;
    logic [23:0]        color;
    logic [9:0]         row;
    logic [TILE_SH-1:0] u;
    logic [TILE_SH-1:0] v;
    logic               kill;
  } mid_t;

  typedef struct packed {
    logic [2:0] tex;
    logic       wall;
    logic       light;
  } cell_t;

  typedef struct packed {
    logic [9:0]  row;
    logic        wr;
    logic [23:0] color;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [1:0] lv,
                                                   input logic [MAP_W-1:0] x,
                                                   input logic [MAP_W-1:0] y);
    cell_addr = CELL_AW'((int'(lv) * MAP_SIDE + int'(y)) * MAP_SIDE + int'(x));
  endfunction

  function automatic logic [TEXEL_AW-1:0] texel_addr(input logic [TEX_AW-1:0] t,
                                                     input logic [TILE_SH-1:0] v,
                                                     input logic [TILE_SH-1:0] u);
    texel_addr = TEXEL_AW'((int'(t) * TILE_SIDE + int'(v)) * TILE_SIDE + int'(u));
  endfunction

endpackage

FILE: rtl/core/floor_cast_texel_shader.sv
// Top level of the floor cast texel shader: configuration registers and wiring.
// Depends on fct_pkg, fct_front, fct_queue and fct_back.
//
// Use: the input side is a queue. Drive a word on the in_ ports with in_push;
// it is taken at a clock edge where in_push is high and in_full is low.
// Operations: load map cell, load texel, cast pixel. Every word gives exactly
// one result word, in order, on the out_ ports while out_empty is low; it is
// taken on an edge where out_pop is high. Loads give an all-zero result.
// Registers are written over cfg_ (index, data); cfg_ready is always high.
// Write them only while no word is in flight.
// Throughput: one word per clock while in_full stays low. On its way to the
// result queue a word passes the 32-stage divider of the distance term, the
// two multiply stages, the world position stage, the mid queue and the two
// memory reads.
// Loads and casts meet the memories at the same pipeline point, so a cast
// always sees every load accepted before it.
// Reset empties all queues and pipeline stages and sets the registers to
// their defaults; map and texel memories keep whatever they held.
// A stalled receiver fills the 4-word result queue, then the back part, then
// the 4-word mid queue holds the front, and in_full rises.
module floor_cast_texel_shader import fct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_operation,
  input  logic [1:0]            in_level,
  input  logic [5:0]            in_cell_x,
  input  logic [5:0]            in_cell_y,
  input  logic [2:0]            in_texture_id,
  input  logic                  in_wall_bit,
  input  logic                  in_light_bit,
  input  logic [23:0]           in_load_color,
  input  logic [9:0]            in_row,
  input  logic signed [15:0]    in_sine_value,
  input  logic signed [15:0]    in_cosine_value,
  input  logic [14:0]           in_fisheye,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [9:0]            out_row,
  output logic                  out_write_pixel,
  output logic [23:0]           out_pixel_color,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers; unknown indexes are dropped
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PLAYER_HEIGHT: cfg_r.player_height       <= cfg_data;
        CFG_HORIZON_ROW:   cfg_r.horizon_row         <= cfg_data[10:0];
        CFG_PROJ_DIST:     cfg_r.projection_distance <= cfg_data[10:0];
        CFG_VIEWER_X:      cfg_r.viewer_x            <= cfg_data;
        CFG_VIEWER_Y:      cfg_r.viewer_y            <= cfg_data;
        CFG_VIEWER_LEVEL:  cfg_r.viewer_level        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // input word as the front sees it
  fitem_t in_item;

  always_comb begin
    in_item.op    = in_operation;
    in_item.lv    = in_level;
    in_item.cx    = in_cell_x;
    in_item.cy    = in_cell_y;
    in_item.tex   = in_texture_id;
    in_item.wall  = in_wall_bit;
    in_item.light = in_light_bit;
    in_item.color = in_load_color;
    in_item.row   = in_row;
    in_item.sn    = in_sine_value;
    in_item.cs    = in_cosine_value;
    in_item.fe    = in_fisheye;
    in_item.kill  = 1'b0;
  end

  // front advances whenever the mid queue can take its output word
  logic    front_en;
  logic    front_v;
  mid_t    front_word;
  logic    mid_pop;
  mid_t    mid_head;
  q_stat_t mid_stat;
  res_t    res_head;

  assign front_en = !mid_stat.full || mid_pop;
  assign in_full  = !front_en;

  fct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (front_en),
    .cfg       (cfg_r),
    .in_valid  (in_push),
    .in_item   (in_item),
    .out_valid (front_v),
    .out_word  (front_word)
  );

  fct_queue u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_en && front_v),
    .push_word (front_word),
    .pop       (mid_pop),
    .head_word (mid_head),
    .stat      (mid_stat)
  );

  fct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_word  (mid_head),
    .mid_stat  (mid_stat),
    .mid_pop   (mid_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (res_head)
  );

  assign out_row         = res_head.row;
  assign out_write_pixel = res_head.wr;
  assign out_pixel_color = res_head.color;

  // a pixel that is not drawn carries no colour
  a_blank_colour: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_write_pixel) |-> (out_pixel_color == 24'd0))
    else $error("undrawn result word carries a colour");

  // back-pressure to the producer only comes from a full mid queue
  a_full_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> mid_stat.full)
    else $error("input stalled while mid queue has room");

  // reset leaves no result word behind
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

endmodule

FILE: rtl/core/fct_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on fct_pkg (div_t, DIV_STAGES).
module fct_divider import fct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  div_t in_word,
  output logic out_valid,
  output div_t out_word
);

  div_t                  stg_r [1:DIV_STAGES];
  logic [DIV_STAGES:1]   vld_r;

  function automatic div_t div_step(input div_t c);
    logic [11:0] trial;
    logic        ge;
    div_t        n;
    trial  = {c.rem, c.sh[31]};
    ge     = trial >= {1'b0, c.den};
    n      = c;
    n.rem  = ge ? 11'(trial - {1'b0, c.den}) : trial[10:0];
    n.sh   = {c.sh[30:0], ge};
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[1] <= div_step(in_word);
      for (int k = 1; k < DIV_STAGES; k++) begin
        stg_r[k+1] <= div_step(stg_r[k]);
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES];
  assign out_word  = stg_r[DIV_STAGES];

endmodule

FILE: rtl/core/fct_front.sv
// Front: input register, decode, distance multiply/divide and world position.
// Depends on fct_pkg and fct_divider.
module fct_front import fct_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  cfg_t   cfg,
  input  logic   in_valid,
  input  fitem_t in_item,
  output logic   out_valid,
  output mid_t   out_word
);

  // stage 1: raw item
  fitem_t s1_r;
  logic   s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_item;
    end
  end

  logic [13:0] num_u;
  logic [12:0] num_mag;
  logic [11:0] den_u;
  logic        den_pos;
  fitem_t      s1_k;

  always_comb begin
    num_u   = 14'(cfg.player_height) - 14'(TILE_SIDE) * 14'(s1_r.lv) + 14'd1;
    num_mag = num_u[13] ? 13'(-num_u) : 13'(num_u);
    den_u   = {2'b00, s1_r.row} - {cfg.horizon_row[10], cfg.horizon_row};
    den_pos = !den_u[11] && (den_u != 12'd0);
    s1_k    = s1_r;
    s1_k.kill = (s1_r.op == OP_CAST) &&
                (!den_pos || (cfg.viewer_level < s1_r.lv) || (int'(s1_r.lv) >= LAYERS));
  end

  // stage 2: |num| * plane distance
  fitem_t      s2_r;
  logic        s2_v_r;
  logic [23:0] p1_r;
  logic        s2_neg_r;
  logic [10:0] s2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r     <= s1_k;
      p1_r     <= 24'(num_mag) * 24'(cfg.projection_distance);
      s2_neg_r <= num_u[13];
      s2_den_r <= den_pos ? den_u[10:0] : 11'd0;
    end
  end

  // stage 3: * fisheye
  fitem_t      s3_r;
  logic        s3_v_r;
  logic [38:0] p2_r;
  logic        s3_neg_r;
  logic [10:0] s3_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r     <= s2_r;
      p2_r     <= 39'(p1_r) * 39'(s2_r.fe);
      s3_neg_r <= s2_neg_r;
      s3_den_r <= s2_den_r;
    end
  end

  // dividend is the product times four; high bits seed the remainder
  logic [40:0] dividend;
  div_t        dv_in;
  div_t        dv_out;
  logic        dv_out_v;

  always_comb begin
    dividend    = {p2_r, 2'b00};
    dv_in.item  = s3_r;
    dv_in.rem   = 11'(dividend[40:32]);
    dv_in.sh    = dividend[31:0];
    dv_in.den   = s3_den_r;
    dv_in.ovf   = 11'(dividend[40:32]) >= s3_den_r;
    dv_in.neg   = s3_neg_r;
  end

  fct_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_word   (dv_in),
    .out_valid (dv_out_v),
    .out_word  (dv_out)
  );

  // stage 4: saturate and sign
  logic               sat;
  logic signed [31:0] dist_sat;
  fitem_t             s4_r;
  logic               s4_v_r;
  logic signed [31:0] dist_r;

  always_comb begin
    sat = dv_out.ovf || dv_out.sh[31];
    if (dv_out.neg) begin
      dist_sat = sat ? 32'sh8000_0000 : signed'(-dv_out.sh);
    end else begin
      dist_sat = sat ? 32'sh7FFF_FFFF : signed'(dv_out.sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= dv_out_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r   <= dv_out.item;
      dist_r <= dist_sat;
    end
  end

  // stage 5: rotate onto the ray
  fitem_t             s5_r;
  logic               s5_v_r;
  logic signed [47:0] px_r;
  logic signed [47:0] py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= s4_r;
      px_r <= 48'(dist_r) * 48'(s4_r.cs);
      py_r <= 48'(dist_r) * 48'(s4_r.sn);
    end
  end

  // world position, cell and texel coordinates
  logic signed [47:0]        rx;
  logic signed [47:0]        ry;
  logic signed [47:0]        sx;
  logic signed [47:0]        sy;
  logic signed [WORLD_W-1:0] wx;
  logic signed [WORLD_W-1:0] wy;
  logic signed [WORLD_W-1:0] mxf;
  logic signed [WORLD_W-1:0] myf;
  logic                      in_map;
  mid_t                      w;

  always_comb begin
    // truncate toward zero: bias negatives before the shift
    rx     = px_r + (px_r[47] ? 48'sd1073741823 : 48'sd0);
    ry     = py_r + (py_r[47] ? 48'sd1073741823 : 48'sd0);
    sx     = rx >>> 30;
    sy     = ry >>> 30;
    wx     = WORLD_W'(sx) + WORLD_W'(cfg.viewer_x);
    wy     = WORLD_W'(sy) + WORLD_W'(cfg.viewer_y);
    mxf    = wx >>> TILE_SH;
    myf    = wy >>> TILE_SH;
    in_map = !wx[WORLD_W-1] && !wy[WORLD_W-1] &&
             (int'(mxf) < MAP_SIDE) && (int'(myf) < MAP_SIDE);

    w       = '0;
    w.op    = s5_r.op;
    w.lv    = s5_r.lv;
    w.tex   = s5_r.tex;
    w.wall  = s5_r.wall;
    w.light = s5_r.light;
    w.color = s5_r.color;
    w.row   = s5_r.row;
    w.kill  = s5_r.kill;
    unique case (s5_r.op)
      OP_LOAD_CELL: begin
        w.cx = MAP_W'(s5_r.cx);
        w.cy = MAP_W'(s5_r.cy);
        w.ok = (int'(s5_r.lv) < LAYERS) && (int'(s5_r.cx) < MAP_SIDE) &&
               (int'(s5_r.cy) < MAP_SIDE);
      end
      OP_LOAD_TEXEL: begin
        w.u  = TILE_SH'(s5_r.cx);
        w.v  = TILE_SH'(s5_r.cy);
        w.ok = int'(s5_r.tex) < TEXTURES;
      end
      OP_CAST: begin
        w.cx   = MAP_W'(mxf);
        w.cy   = MAP_W'(myf);
        w.u    = wx[TILE_SH-1:0];
        w.v    = wy[TILE_SH-1:0];
        w.ok   = in_map;
        w.kill = s5_r.kill || !in_map;
      end
      default: begin
        w.ok = 1'b0;
      end
    endcase
  end

  // stage 6: front output register
  mid_t w_r;
  logic w_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r <= 1'b0;
    end else if (en) begin
      w_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w;
    end
  end

  assign out_valid = w_v_r;
  assign out_word  = w_r;

endmodule

FILE: rtl/core/fct_queue.sv
// Short queue of front words between the front and back parts.
// Depends on fct_pkg (mid_t, q_stat_t, MID_DEPTH).
module fct_queue import fct_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  mid_t    push_word,
  input  logic    pop,
  output mid_t    head_word,
  output q_stat_t stat
);

  mid_t              mem_r [0:MID_DEPTH-1];
  logic [MID_AW-1:0] wr_ptr_r;
  logic [MID_AW-1:0] rd_ptr_r;
  logic [MID_AW:0]   cnt_r;
  logic [MID_AW:0]   cnt_nxt;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  assign head_word  = mem_r[rd_ptr_r];
  assign stat.full  = int'(cnt_r) == MID_DEPTH;
  assign stat.empty = cnt_r == '0;

endmodule

FILE: rtl/core/fct_back.sv
// Back: cell map and texel memories, shading and the result queue.
// Depends on fct_pkg.
module fct_back import fct_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mid_t    mid_word,
  input  q_stat_t mid_stat,
  output logic    mid_pop,
  input  logic    out_pop,
  output logic    out_empty,
  output res_t    out_word
);

  logic [OUT_AW:0]   cnt_r;
  logic [OUT_AW:0]   cnt_nxt;
  logic [OUT_AW-1:0] wr_ptr_r;
  logic [OUT_AW-1:0] rd_ptr_r;
  res_t              fifo_r [0:OUT_DEPTH-1];
  logic              out_fire;
  logic              back_en;
  logic              push;

  assign out_fire = out_pop && (cnt_r != '0);
  assign back_en  = (int'(cnt_r) < OUT_DEPTH) || out_fire;
  assign mid_pop  = back_en && !mid_stat.empty;

  // B1: map lookup of the cell and the one below it
  cell_t              cell_mem [0:CELL_COUNT-1];
  logic [CELL_AW-1:0] addr_here;
  logic [CELL_AW-1:0] addr_below;
  cell_t              here_r;
  cell_t              below_r;
  mid_t               b1_r;
  logic               b1_v_r;

  assign addr_here  = cell_addr(mid_word.lv, mid_word.cx, mid_word.cy);
  assign addr_below = cell_addr(mid_word.lv - 2'd1, mid_word.cx, mid_word.cy);

  always_ff @(posedge clk) begin
    if (back_en) begin
      if (mid_pop && (mid_word.op == OP_LOAD_CELL) && mid_word.ok) begin
        cell_mem[addr_here] <= '{mid_word.tex, mid_word.wall, mid_word.light};
      end
      here_r  <= cell_mem[addr_here];
      below_r <= cell_mem[addr_below];
      b1_r    <= mid_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (back_en) begin
      b1_v_r <= mid_pop;
    end
  end

  // B2: layer check and texel fetch
  logic                upper_blocked;
  logic                draw;
  logic [TEX_AW-1:0]   tex_num;
  logic [TEXEL_AW-1:0] tex_addr;
  logic                tex_load;
  logic [23:0]         texel_mem [0:TEXEL_COUNT-1];
  logic [23:0]         texel_r;
  logic                b2_v_r;
  logic                b2_draw_r;
  logic                b2_light_r;
  logic [9:0]          b2_row_r;

  always_comb begin
    upper_blocked = (b1_r.lv != 2'd0) && (!below_r.wall || here_r.wall);
    draw          = (b1_r.op == OP_CAST) && b1_r.ok && !b1_r.kill && !upper_blocked;
    tex_load      = b1_r.op == OP_LOAD_TEXEL;
    tex_num       = tex_load ? TEX_AW'(b1_r.tex) : TEX_AW'(int'(here_r.tex) % TEXTURES);
    tex_addr      = texel_addr(tex_num, b1_r.v, b1_r.u);
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      if (b1_v_r && tex_load && b1_r.ok) begin
        texel_mem[tex_addr] <= b1_r.color;
      end
      texel_r    <= texel_mem[tex_addr];
      b2_draw_r  <= draw;
      b2_light_r <= here_r.light;
      b2_row_r   <= (b1_r.op == OP_CAST) ? b1_r.row : 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (back_en) begin
      b2_v_r <= b1_v_r;
    end
  end

  // shading into the result queue
  res_t res;

  always_comb begin
    res.row   = b2_row_r;
    res.wr    = b2_draw_r;
    res.color = !b2_draw_r ? 24'd0 :
                b2_light_r ? ((texel_r >> 1) & HALF_MASK) : texel_r;
  end

  assign push = back_en && b2_v_r;

  always_comb begin
    unique case ({push, out_fire})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  assign out_empty = cnt_r == '0;
  assign out_word  = fifo_r[rd_ptr_r];

endmodule

FILE: tb/tb_floor_cast_texel_shader.sv
`timescale 1ns / 100ps
// Self-checking testbench for floor_cast_texel_shader: directed table, then random words.
// Depends on fct_pkg and the RTL of the block; nothing else.
module tb_floor_cast_texel_shader;
  import fct_pkg::*;

  // one input word as the sender sees it
  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         lv;
    logic [5:0]         cx;
    logic [5:0]         cy;
    logic [2:0]         tex;
    logic               wall;
    logic               light;
    logic [23:0]        color;
    logic [9:0]         row;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    logic [14:0]        fe;
  } word_t;

  // directed row: word plus an optional hand-typed result
  typedef struct packed {
    word_t w;
    bit    typed;
    res_t  want;
  } dir_row_t;

  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 190;
  localparam int SETTLE = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_operation = '0;
  logic [1:0] in_level = '0;
  logic [5:0] in_cell_x = '0;
  logic [5:0] in_cell_y = '0;
  logic [2:0] in_texture_id = '0;
  logic in_wall_bit = 1'b0;
  logic in_light_bit = 1'b0;
  logic [23:0] in_load_color = '0;
  logic [9:0] in_row = '0;
  logic signed [15:0] in_sine_value = '0;
  logic signed [15:0] in_cosine_value = '0;
  logic [14:0] in_fisheye = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [9:0] out_row;
  logic out_write_pixel;
  logic [23:0] out_pixel_color;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  floor_cast_texel_shader uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the block: registers and the four stores
  cfg_t        regs;
  logic [2:0]  floor_tex [CELL_COUNT];
  bit          wall_at   [CELL_COUNT];
  bit          lit_at    [CELL_COUNT];
  logic [23:0] texels    [TEXEL_COUNT];
  bit          cell_known  [CELL_COUNT];
  bit          texel_known [TEXEL_COUNT];

  res_t pending_px[$];   // expected result words, oldest first
  int   errors = 0;
  int   words_sent = 0;
  int   casts_sent = 0;
  int   pixels_drawn = 0;
  int   words_checked = 0;
  bit   calm = 1'b0;     // no idling on either side
  int   hold_ask = 0;    // receiver long stall requests
  int   hold_seen = 0;
  int   hold_left = 0;

  // Projects a cast onto the floor of its layer. hit is set only when the
  // ray passes the horizon/level tests and lands inside the map.
  function automatic void project(input word_t w, output bit hit,
                                  output int mx, output int my,
                                  output logic [5:0] u, output logic [5:0] v);
    longint den, num, dist_q, wx, wy;
    hit = 1'b0;
    mx = 0;
    my = 0;
    den = longint'(w.row) - longint'(regs.horizon_row);
    if (den <= 0 || regs.viewer_level < w.lv || w.lv >= LAYERS) return;
    num = longint'(regs.player_height) - longint'(TILE_SIDE) * longint'(w.lv) + 1;
    dist_q = num * longint'(regs.projection_distance) * longint'(w.fe) * 4 / den;
    if (dist_q > 64'sh7FFF_FFFF) dist_q = 64'sh7FFF_FFFF;
    if (dist_q < -64'sh8000_0000) dist_q = -64'sh8000_0000;
    wx = dist_q * longint'(w.cs) / (longint'(1) << 30) + longint'(regs.viewer_x);
    wy = dist_q * longint'(w.sn) / (longint'(1) << 30) + longint'(regs.viewer_y);
    u = wx[5:0];
    v = wy[5:0];
    wx = wx >>> TILE_SH;
    wy = wy >>> TILE_SH;
    if (wx < 0 || wx >= MAP_SIDE || wy < 0 || wy >= MAP_SIDE) return;
    mx = int'(wx);
    my = int'(wy);
    hit = 1'b1;
  endfunction

  function automatic int cell_idx(input int lv, input int x, input int y);
    return (lv * MAP_SIDE + y) * MAP_SIDE + x;
  endfunction

  // Applies one accepted word to the shadow state and returns its result.
  function automatic res_t shade_word(input word_t w);
    res_t r;
    bit hit;
    int mx, my, ci, ti;
    logic [5:0] u, v;
    r = '0;
    case (w.op)
      OP_LOAD_CELL: begin
        ci = cell_idx(w.lv, w.cx, w.cy);
        floor_tex[ci] = w.tex;
        wall_at[ci] = w.wall;
        lit_at[ci] = w.light;
        cell_known[ci] = 1'b1;
      end
      OP_LOAD_TEXEL: begin
        ti = (int'(w.tex) * TILE_SIDE + w.cy) * TILE_SIDE + w.cx;
        texels[ti] = w.color;
        texel_known[ti] = 1'b1;
      end
      OP_CAST: begin
        r.row = w.row;
        project(w, hit, mx, my, u, v);
        if (hit) begin
          ci = cell_idx(w.lv, mx, my);
          // upper layers draw only on top of a wall and never inside one
          if (w.lv == 0 || (wall_at[cell_idx(w.lv - 1, mx, my)] && !wall_at[ci])) begin
            r.wr = 1'b1;
            r.color = texels[(int'(floor_tex[ci]) * TILE_SIDE + v) * TILE_SIDE + u];
            if (lit_at[ci]) r.color = (r.color >> 1) & HALF_MASK;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one word, holding it until taken; expectation logged at the taking edge.
  task automatic send_word(input word_t w, input bit typed, input res_t want);
    res_t got;
    while (!calm && $urandom_range(99) < 7) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_operation <= w.op;
    in_level <= w.lv;
    in_cell_x <= w.cx;
    in_cell_y <= w.cy;
    in_texture_id <= w.tex;
    in_wall_bit <= w.wall;
    in_light_bit <= w.light;
    in_load_color <= w.color;
    in_row <= w.row;
    in_sine_value <= w.sn;
    in_cosine_value <= w.cs;
    in_fisheye <= w.fe;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    got = shade_word(w);
    pending_px.push_back(typed ? want : got);
    words_sent++;
    if (w.op == OP_CAST) begin
      casts_sent++;
      if (got.wr) pixels_drawn++;
    end
  endtask

  function automatic word_t rand_word();
    word_t w;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(word_t)-1:0];
    return w;
  endfunction

  task automatic send_cell(input int lv, input int x, input int y);
    word_t w;
    w = rand_word();
    w.op = OP_LOAD_CELL;
    w.lv = lv;
    w.cx = x;
    w.cy = y;
    send_word(w, 1'b0, '0);
  endtask

  // Casts land only on loaded cells and texels: whatever the ray would read
  // is loaded first, with random contents.
  task automatic send_cast(input word_t w, input bit typed, input res_t want);
    bit hit;
    int mx, my, ti;
    logic [5:0] u, v;
    word_t t;
    w.op = OP_CAST;
    project(w, hit, mx, my, u, v);
    if (hit) begin
      if (w.lv > 0 && !cell_known[cell_idx(w.lv - 1, mx, my)]) send_cell(w.lv - 1, mx, my);
      if (!cell_known[cell_idx(w.lv, mx, my)]) send_cell(w.lv, mx, my);
      ti = (int'(floor_tex[cell_idx(w.lv, mx, my)]) * TILE_SIDE + v) * TILE_SIDE + u;
      if (!texel_known[ti]) begin
        t = rand_word();
        t.op = OP_LOAD_TEXEL;
        t.tex = floor_tex[cell_idx(w.lv, mx, my)];
        t.cx = u;
        t.cy = v;
        send_word(t, 1'b0, '0);
      end
    end
    send_word(w, typed, want);
  endtask

  task automatic random_item();
    word_t w;
    int pick, r;
    w = rand_word();
    pick = $urandom_range(99);
    if (pick < 55) begin
      // mostly well-formed cast: mostly below the horizon and within the viewer's levels
      w.lv = ($urandom_range(9) < 8) ? 2'($urandom_range(regs.viewer_level)) : w.lv;
      r = int'(regs.horizon_row) + 1 + $urandom_range(150);
      w.row = (r > 1023 || r < 0) ? 10'($urandom) : 10'(r);
      w.sn = 16'($signed($urandom_range(32768)) - 16384);
      w.cs = 16'($signed($urandom_range(32768)) - 16384);
      if ($urandom_range(9) < 8) w.fe = 15'($urandom_range(19000, 14000));
      send_cast(w, 1'b0, '0);
    end else if (pick < 75) begin
      w.op = OP_LOAD_CELL;
      send_word(w, 1'b0, '0);
    end else if (pick < 90) begin
      w.op = OP_LOAD_TEXEL;
      send_word(w, 1'b0, '0);
    end else if (pick < 95) begin
      w.op = 2'd3;   // unused code, all-zero result
      send_word(w, 1'b0, '0);
    end else begin
      send_cast(w, 1'b0, '0);   // raw cast, any fields
    end
  endtask

  task automatic drain();
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all six registers back to back; only called with the block idle.
  task automatic write_regs(input cfg_t c);
    logic [CFG_DATA_W-1:0] vals [6];
    logic [CFG_IDX_W-1:0]  idx  [6];
    vals = '{c.player_height, 12'(c.horizon_row), 12'(c.projection_distance),
             c.viewer_x, c.viewer_y, 12'(c.viewer_level)};
    idx = '{CFG_PLAYER_HEIGHT, CFG_HORIZON_ROW, CFG_PROJ_DIST,
            CFG_VIEWER_X, CFG_VIEWER_Y, CFG_VIEWER_LEVEL};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    regs = c;
  endtask

  // Result side: compare each taken word with the oldest expectation.
  always @(posedge clk) begin
    res_t ex;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result row=%0d wr=%0b color=%06h", $time,
                 out_row, out_write_pixel, out_pixel_color);
        errors++;
      end else begin
        ex = pending_px.pop_front();
        words_checked++;
        if (out_row !== ex.row) begin
          $display("%0t: row expected %0d actual %0d", $time, ex.row, out_row);
          errors++;
        end
        if (out_write_pixel !== ex.wr) begin
          $display("%0t: write_pixel expected %0b actual %0b", $time, ex.wr,
                   out_write_pixel);
          errors++;
        end
        if (out_pixel_color !== ex.color) begin
          $display("%0t: pixel_color expected %06h actual %06h", $time, ex.color,
                   out_pixel_color);
          errors++;
        end
      end
    end
    // long receiver stall on request, counted here, so the block backs up
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= 250;
      out_pop <= 1'b0;
    end else begin
      out_pop <= calm || ($urandom_range(99) >= 7);
    end
  end

  initial begin
    #2_000_000;
    $display("floor_cast_texel_shader regression: fail");
    $finish;
  end

  initial begin
    dir_row_t dir [13];
    cfg_t phase_cfg [PHASES];
    dir_row_t d;
    // reset config: height 32, horizon 0, plane 277, viewer at origin on level 0
    dir[0]  = '{'{2'd3, 2'd3, 6'd63, 6'd63, 3'd7, 1'b1, 1'b1, 24'hFFFFFF, 10'd1023,
                 -16'sd16384, 16'sd16384, 15'h7FFF}, 1'b1, '0};
    dir[1]  = '{'{OP_LOAD_CELL, 2'd0, 6'd0, 6'd0, 3'd5, 1'b0, 1'b1, 24'h0, 10'd0,
                 16'sd0, 16'sd0, 15'd0}, 1'b1, '0};
    dir[2]  = '{'{OP_LOAD_CELL, 2'd3, 6'd63, 6'd63, 3'd7, 1'b1, 1'b1, 24'hFFFFFF,
                 10'd1023, 16'sd16384, -16'sd16384, 15'h7FFF}, 1'b1, '0};
    dir[3]  = '{'{OP_LOAD_TEXEL, 2'd0, 6'd0, 6'd0, 3'd5, 1'b0, 1'b0, 24'hFFFFFF,
                 10'd0, 16'sd0, 16'sd0, 15'd0}, 1'b1, '0};
    dir[4]  = '{'{OP_LOAD_TEXEL, 2'd0, 6'd63, 6'd63, 3'd0, 1'b0, 1'b0, 24'h000000,
                 10'd0, 16'sd0, 16'sd0, 15'd0}, 1'b1, '0};
    // zero fisheye: ray lands under the viewer, lit cell halves white
    dir[5]  = '{'{OP_CAST, 2'd0, 6'd0, 6'd0, 3'd0, 1'b0, 1'b0, 24'h0, 10'd10,
                 16'sd16384, -16'sd16384, 15'd0}, 1'b1, '{10'd10, 1'b1, 24'h7F7F7F}};
    // row on the horizon
    dir[6]  = '{'{OP_CAST, 2'd0, 6'd0, 6'd0, 3'd0, 1'b0, 1'b0, 24'h0, 10'd0,
                 16'sd0, 16'sd16384, 15'd16384}, 1'b1, '{10'd0, 1'b0, 24'h0}};
    // layer above the viewer
    dir[7]  = '{'{OP_CAST, 2'd3, 6'd0, 6'd0, 3'd0, 1'b0, 1'b0, 24'h0, 10'd1023,
                 16'sd0, 16'sd16384, 15'd16384}, 1'b1, '{10'd1023, 1'b0, 24'h0}};
    // far distance just under the horizon, off the map to both sides
    dir[8]  = '{'{OP_CAST, 2'd0, 6'd0, 6'd0, 3'd0, 1'b0, 1'b0, 24'h0, 10'd1,
                 -16'sd16384, -16'sd16384, 15'h7FFF}, 1'b1, '{10'd1, 1'b0, 24'h0}};
    dir[9]  = '{'{OP_CAST, 2'd0, 6'd0, 6'd0, 3'd0, 1'b0, 1'b0, 24'h0, 10'd1,
                 16'sd16384, 16'sd16384, 15'h7FFF}, 1'b1, '{10'd1, 1'b0, 24'h0}};
    dir[10] = '{'{OP_LOAD_CELL, 2'd0, 6'd1, 6'd0, 3'd2, 1'b0, 1'b0, 24'h0, 10'd0,
                 16'sd0, 16'sd0, 15'd0}, 1'b1, '0};
    dir[11] = '{'{OP_CAST, 2'd0, 6'd0, 6'd0, 3'd0, 1'b0, 1'b0, 24'h0, 10'd100,
                 16'sd0, 16'sd16384, 15'd16384}, 1'b0, '0};
    dir[12] = '{'{OP_CAST, 2'd0, 6'd0, 6'd0, 3'd0, 1'b0, 1'b0, 24'h0, 10'd50,
                 16'sd0, 16'sd0, 15'd16384}, 1'b0, '0};

    phase_cfg[0] = '{12'd32, 11'sd100, 11'd277, 12'd2048, 12'd2048, 2'd0};
    phase_cfg[1] = '{12'd100, -11'sd512, 11'd160, 12'd1000, 12'd3000, 2'd1};
    phase_cfg[2] = '{12'd200, 11'sd300, 11'd2047, 12'd4095, 12'd0, 2'd3};
    phase_cfg[3] = '{12'd0, 11'sd1023, 11'd0, 12'd0, 12'd4095, 2'd2};
    phase_cfg[4] = '{12'd4095, 11'sd50, 11'd100, 12'd2048, 12'd2048, 2'd3};
    phase_cfg[5] = '{12'd150, 11'sd200, 11'd400, 12'd1500, 12'd2500, 2'd3};

    regs = CFG_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir[i]) begin
      d = dir[i];
      if (d.w.op == OP_CAST) send_cast(d.w, d.typed, d.want);
      else send_word(d.w, d.typed, d.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      in_push <= 1'b0;
      drain();   // sender waits for every result before the registers move
      write_regs(phase_cfg[p]);
      calm = (p == 2);
      if (p == 1) hold_ask++;   // receiver backs off while words keep coming
      for (int n = words_sent + PHASE_WORDS; words_sent < n; ) random_item();
    end
    calm = 1'b0;
    in_push <= 1'b0;
    drain();

    $display("run: %0d words in, %0d results checked, %0d casts, %0d pixels drawn",
             words_sent, words_checked, casts_sent, pixels_drawn);
    $display("covered reset and %0d register settings, stalls on both sides", PHASES);
    if (errors == 0 && pending_px.size() == 0) begin
      $display("floor_cast_texel_shader regression: pass");
    end else begin
      $display("floor_cast_texel_shader regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/fct_pkg.sv
rtl/core/fct_divider.sv
rtl/core/fct_front.sv
rtl/core/fct_queue.sv
rtl/core/fct_back.sv
rtl/core/floor_cast_texel_shader.sv
tb/tb_floor_cast_texel_shader.sv
